>>> rtl/core/lsbb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsbb_pkg
// Shared types and constants of the line-sensor bang-bang steering block.
// ----------------------------------------------------------------------------
package lsbb_pkg;

    localparam int CHANNELS_DEF    = 8;
    localparam int SAMPLE_BITS_DEF = 10;
    localparam int NORM_FULL       = 1000;
    localparam int MIN_RANGE       = 50;
    localparam int DUTY_MAX        = 255;
    localparam int NORM_BITS       = 10;
    localparam int CFG_IDX_BITS    = 3;
    localparam int CFG_DATA_BITS   = 13;

    typedef enum logic [1:0] {
        ACT_CLEAR = 2'd0,
        ACT_CAL   = 2'd1,
        ACT_RUN   = 2'd2,
        ACT_NONE  = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        ST_STOP     = 3'd0,
        ST_STRAIGHT = 3'd1,
        ST_GENTLE_R = 3'd2,
        ST_HARD_R   = 3'd3,
        ST_GENTLE_L = 3'd4,
        ST_HARD_L   = 3'd5
    } t_steer;

    typedef enum logic [2:0] {
        REG_INT_THR   = 3'd0,
        REG_TOT_THR   = 3'd1,
        REG_HARD      = 3'd2,
        REG_GENTLE    = 3'd3,
        REG_MAX_SPD   = 3'd4,
        REG_BASE_SPD  = 3'd5,
        REG_REV_SPD   = 3'd6,
        REG_SPARE     = 3'd7
    } t_reg_idx;

    typedef enum logic [2:0] {
        SQ_IDLE,
        SQ_CHAN,
        SQ_DIV,
        SQ_ACCUM,
        SQ_MUL,
        SQ_DECIDE,
        SQ_OUT
    } t_seq;

    typedef struct packed {
        logic [1:0] action;
        logic [9:0] sample_7;
        logic [9:0] sample_6;
        logic [9:0] sample_5;
        logic [9:0] sample_4;
        logic [9:0] sample_3;
        logic [9:0] sample_2;
        logic [9:0] sample_1;
        logic [9:0] sample_0;
    } t_in_item;

    typedef struct packed {
        logic [2:0] steer_state;
        logic [7:0] left_duty;
        logic       left_reverse;
        logic [7:0] right_duty;
        logic       right_reverse;
    } t_out_item;

    typedef struct packed {
        logic [CFG_IDX_BITS-1:0]  index;
        logic [CFG_DATA_BITS-1:0] data;
    } t_cfg_wr;

    // Divider handshake between sequencer and divider.
    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } t_div_ctl;

endpackage

>>> rtl/core/lsbb_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsbb_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lsbb_div #(
    parameter int NUM_BITS = 17,
    parameter int DEN_BITS = 11
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [NUM_BITS-1:0] i_num,
    input  logic [DEN_BITS-1:0] i_den,
    output logic                o_busy,
    output logic                o_done,
    output logic [NUM_BITS-1:0] o_quot
);
    localparam int CNT_BITS = $clog2(NUM_BITS + 1);

    logic [NUM_BITS-1:0] r_quot, n_quot;
    logic [DEN_BITS:0]   r_rem, n_rem;
    logic [DEN_BITS-1:0] r_den;
    logic [CNT_BITS-1:0] r_cnt, n_cnt;
    logic                r_busy, r_done;
    logic [DEN_BITS:0]   w_trial;

    always_comb begin
        w_trial = {r_rem[DEN_BITS-1:0], r_quot[NUM_BITS-1]};
        n_quot  = {r_quot[NUM_BITS-2:0], 1'b0};
        n_rem   = w_trial;
        if (w_trial >= {1'b0, r_den}) begin
            n_rem     = w_trial - {1'b0, r_den};
            n_quot[0] = 1'b1;
        end
        n_cnt = r_cnt - CNT_BITS'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_BITS'(NUM_BITS);
            end else if (r_busy) begin
                r_cnt <= n_cnt;
                if (n_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start && !r_busy) begin
            r_quot <= i_num;
            r_rem  <= '0;
            r_den  <= i_den;
        end else if (r_busy) begin
            r_quot <= n_quot;
            r_rem  <= n_rem;
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quot = r_quot;

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(r_busy))
        else $error("divider done without busy");
    a_no_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_busy) |-> r_cnt == CNT_BITS'(NUM_BITS))
        else $error("divider count not loaded");
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("divider done longer than one cycle");
endmodule

>>> rtl/core/line_sensor_bang_bang_steering.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_sensor_bang_bang_steering
// Calibrates per-channel reflectance ranges and steers from the line centroid.
//
//  channel | valid / ready          | payload
//  input   | i_in_valid / o_in_ready  | i_in_data  (t_in_item)
//  output  | o_out_valid / i_out_ready| o_out_data (t_out_item)
//  config  | i_cfg_valid / o_cfg_ready| i_cfg_data (t_cfg_wr)
//
//  Clear, calibrate: one channel per cycle in the channel step, then the decide
//  and output steps present the result.
//  Run: each in-range channel goes through the divide step (unless its sample is
//  at or below the minimum) and the accumulate step; the shared restoring divider
//  (one quotient bit per cycle) and one shared multiplier do the arithmetic.
//  Ready stays low from acceptance until the result is taken.
//  Reset is synchronous; calibration memory resets in place (flip-flops).
// ----------------------------------------------------------------------------
module line_sensor_bang_bang_steering (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  lsbb_pkg::t_in_item i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output lsbb_pkg::t_out_item o_out_data,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  lsbb_pkg::t_cfg_wr  i_cfg_data
);
    import lsbb_pkg::*;

    localparam int CHANNELS    = CHANNELS_DEF;
    localparam int SAMPLE_BITS = SAMPLE_BITS_DEF;
    localparam int CH_BITS  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int NUM_BITS = SAMPLE_BITS + 10;       // diff * 1000
    localparam int DEN_BITS = SAMPLE_BITS;
    localparam int WMAX     = 10 * (CHANNELS - 1);
    localparam int W_BITS   = $clog2(WMAX + 1) + 1;
    localparam int SV_BITS  = NORM_BITS + CH_BITS + 1;
    localparam int SW_BITS  = SV_BITS + W_BITS + 1;
    localparam int MUL_A    = SV_BITS + 1;
    localparam int MUL_B    = (W_BITS > 8) ? W_BITS : 8;
    localparam int SAMP_MAX = (1 << SAMPLE_BITS) - 1;

    // Configuration registers.
    logic [9:0]  r_int_thr;
    logic [12:0] r_tot_thr;
    logic [6:0]  r_hard, r_gentle;
    logic [7:0]  r_max_spd, r_base_spd, r_rev_spd;
    logic        r_spare;

    // Calibration store.
    logic [SAMPLE_BITS-1:0] r_min [CHANNELS];
    logic [SAMPLE_BITS-1:0] r_max [CHANNELS];

    t_seq                   r_state, n_state;
    logic [CH_BITS-1:0]     r_ch;
    logic                   r_last;
    t_action                r_act;
    logic [SAMPLE_BITS-1:0] r_samp [CHANNELS];
    logic [NORM_BITS-1:0]   r_norm;
    logic signed [SW_BITS-1:0] r_sw;
    logic [SV_BITS-1:0]     r_sv;
    logic signed [SW_BITS-1:0] r_hard_p, r_gentle_p;
    logic                   r_mul_sel;
    logic                   r_out_valid;
    t_out_item              r_out;

    logic                   w_div_start, w_div_busy, w_div_done;
    logic [NUM_BITS-1:0]    w_quot;
    logic [SAMPLE_BITS-1:0] w_v, w_lo, w_hi;
    logic [SAMPLE_BITS:0]   w_range;
    logic                   w_skip, w_below;
    logic [NUM_BITS-1:0]    w_num;
    logic [NORM_BITS-1:0]   w_norm;
    logic signed [W_BITS-1:0] w_wt;
    logic signed [MUL_A-1:0]  w_ma;
    logic signed [MUL_B:0]    w_mb;
    logic signed [SW_BITS-1:0] w_prod;
    t_out_item              w_res;
    logic                   w_in_fire, w_out_fire;

    assign o_in_ready  = (r_state == SQ_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign w_in_fire   = i_in_valid && o_in_ready;
    assign w_out_fire  = r_out_valid && i_out_ready;

    // Channel operands.
    always_comb begin
        w_v     = r_samp[r_ch];
        w_lo    = r_min[r_ch];
        w_hi    = r_max[r_ch];
        w_range = {1'b0, w_hi} - {1'b0, w_lo};
        w_skip  = (w_hi < w_lo) || (w_range < (SAMPLE_BITS+1)'(MIN_RANGE));
        w_below = (w_v <= w_lo);
        w_num   = NUM_BITS'(w_v - w_lo) * NUM_BITS'(NORM_FULL);
        w_norm  = (w_quot > NUM_BITS'(NORM_FULL)) ? NORM_BITS'(NORM_FULL)
                                                  : w_quot[NORM_BITS-1:0];
        w_wt    = W_BITS'(20 * int'(r_ch)) - W_BITS'(WMAX);
    end

    // Shared multiplier: norm*weight during accumulation, limit*sum at the end.
    always_comb begin
        if (r_state == SQ_ACCUM) begin
            w_ma = MUL_A'($signed({1'b0, r_norm}));
            w_mb = (MUL_B+1)'(w_wt);
        end else begin
            w_ma = MUL_A'($signed({1'b0, r_sv}));
            w_mb = r_mul_sel ? (MUL_B+1)'($signed({1'b0, r_gentle}))
                             : (MUL_B+1)'($signed({1'b0, r_hard}));
        end
        w_prod = SW_BITS'(w_ma * w_mb);
    end

    lsbb_div #(.NUM_BITS(NUM_BITS), .DEN_BITS(DEN_BITS)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_num),
        .i_den   (w_range[DEN_BITS-1:0]),
        .o_busy  (w_div_busy),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            SQ_IDLE:   if (w_in_fire) n_state = SQ_CHAN;
            SQ_CHAN: begin
                if (r_act == ACT_RUN && !w_skip && !w_below) n_state = SQ_DIV;
                else if (r_act == ACT_RUN && !w_skip) n_state = SQ_ACCUM;
                else if (r_last) n_state = (r_act == ACT_RUN) ? SQ_MUL : SQ_DECIDE;
            end
            SQ_DIV:    if (w_div_done) n_state = SQ_ACCUM;
            SQ_ACCUM:  n_state = r_last ? SQ_MUL : SQ_CHAN;
            SQ_MUL:    if (r_mul_sel) n_state = SQ_DECIDE;
            SQ_DECIDE: n_state = SQ_OUT;
            SQ_OUT:    if (!r_out_valid || w_out_fire) n_state = SQ_IDLE;
            default:   n_state = SQ_IDLE;
        endcase
    end

    // Outputs of the sequencer.
    always_comb begin
        w_div_start = (r_state == SQ_CHAN) && (r_act == ACT_RUN) && !w_skip && !w_below;
    end

    function automatic logic [8:0] drive(input logic [7:0] mag, input logic rev);
        if (rev && mag != 8'd0) return {8'(DUTY_MAX) - mag, 1'b1};
        return {mag, 1'b0};
    endfunction

    always_comb begin
        logic [7:0] lm, rm;
        logic       lr, rr;
        t_steer     st;
        st = ST_STOP; lm = '0; rm = '0; lr = 1'b0; rr = 1'b0;
        if (r_act == ACT_RUN && r_sv > SV_BITS'(r_tot_thr)) begin
            priority if (r_sw > r_hard_p) begin
                st = ST_HARD_R; lm = r_max_spd; rm = r_rev_spd; rr = 1'b1;
            end else if (r_sw > r_gentle_p) begin
                st = ST_GENTLE_R; lm = r_max_spd;
            end else if (r_sw < -r_hard_p) begin
                st = ST_HARD_L; lm = r_rev_spd; lr = 1'b1; rm = r_max_spd;
            end else if (r_sw < -r_gentle_p) begin
                st = ST_GENTLE_L; rm = r_max_spd;
            end else begin
                st = ST_STRAIGHT; lm = r_base_spd; rm = r_base_spd;
            end
        end
        w_res.steer_state = st;
        {w_res.left_duty, w_res.left_reverse}   = drive(lm, lr);
        {w_res.right_duty, w_res.right_reverse} = drive(rm, rr);
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= SQ_IDLE;
            r_out_valid <= 1'b0;
            r_ch        <= '0;
            r_last      <= 1'b0;
            r_mul_sel   <= 1'b0;
            r_int_thr   <= 10'd200;
            r_tot_thr   <= 13'd400;
            r_hard      <= 7'd35;
            r_gentle    <= 7'd10;
            r_max_spd   <= 8'd45;
            r_base_spd  <= 8'd30;
            r_rev_spd   <= 8'd15;
            r_spare     <= 1'b0;
            for (int i = 0; i < CHANNELS; i++) begin
                r_min[i] <= SAMPLE_BITS'(SAMP_MAX);
                r_max[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (w_out_fire) r_out_valid <= 1'b0;
            if (i_cfg_valid) begin
                unique case (t_reg_idx'(i_cfg_data.index))
                    REG_INT_THR:  r_int_thr  <= i_cfg_data.data[9:0];
                    REG_TOT_THR:  r_tot_thr  <= i_cfg_data.data[12:0];
                    REG_HARD:     r_hard     <= i_cfg_data.data[6:0];
                    REG_GENTLE:   r_gentle   <= i_cfg_data.data[6:0];
                    REG_MAX_SPD:  r_max_spd  <= i_cfg_data.data[7:0];
                    REG_BASE_SPD: r_base_spd <= i_cfg_data.data[7:0];
                    REG_REV_SPD:  r_rev_spd  <= i_cfg_data.data[7:0];
                    REG_SPARE:    r_spare    <= i_cfg_data.data[0];
                    default:      r_spare    <= r_spare;
                endcase
            end
            if (w_in_fire) begin
                r_ch      <= '0;
                r_last    <= (CHANNELS == 1);
                r_mul_sel <= 1'b0;
            end
            if (r_state == SQ_CHAN) begin
                // Clear and calibrate finish a channel here.
                if (r_act == ACT_CLEAR) begin
                    r_min[r_ch] <= SAMPLE_BITS'(SAMP_MAX);
                    r_max[r_ch] <= '0;
                end else if (r_act == ACT_CAL) begin
                    if (w_v < w_lo) r_min[r_ch] <= w_v;
                    if (w_v > w_hi) r_max[r_ch] <= w_v;
                end
                if (!(r_act == ACT_RUN && !w_skip) && !r_last) begin
                    r_ch   <= r_ch + CH_BITS'(1);
                    r_last <= (r_ch == CH_BITS'(CHANNELS - 2));
                end
            end
            if (r_state == SQ_ACCUM && !r_last) begin
                r_ch   <= r_ch + CH_BITS'(1);
                r_last <= (r_ch == CH_BITS'(CHANNELS - 2));
            end
            if (r_state == SQ_MUL) r_mul_sel <= 1'b1;
            if (r_state == SQ_DECIDE) r_out_valid <= 1'b1;
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_act <= t_action'(i_in_data.action);
            for (int i = 0; i < CHANNELS; i++) begin
                r_samp[i] <= i_in_data[SAMPLE_BITS*i +: SAMPLE_BITS];
            end
            r_sw <= '0;
            r_sv <= '0;
        end
        if (r_state == SQ_CHAN) r_norm <= '0;
        if (w_div_done) r_norm <= w_norm;
        if (r_state == SQ_ACCUM && r_norm > r_int_thr) begin
            r_sw <= r_sw + w_prod;
            r_sv <= r_sv + SV_BITS'(r_norm);
        end
        if (r_state == SQ_MUL) begin
            if (r_mul_sel) r_gentle_p <= w_prod;
            else           r_hard_p   <= w_prod;
        end
        if (r_state == SQ_DECIDE) r_out <= w_res;
    end

    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_fire |=> !o_in_ready)
        else $error("accepted a second item while busy");
    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == SQ_DECIDE) |=> o_out_valid)
        else $error("result not presented");
    a_div_only_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_start |-> r_act == ACT_RUN)
        else $error("divider started outside a run sweep");
    a_div_busy_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_busy |-> r_state == SQ_DIV)
        else $error("divider busy outside the divide step");
    a_stop_duty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.steer_state == ST_STOP) |->
        (o_out_data.left_duty == '0 && o_out_data.right_duty == '0))
        else $error("stop result with nonzero duty");
endmodule
